// ===== src/sese_pkg.sv =====
// shared constants and types for the steepest-edge entering-column selector
package sese_pkg;

    localparam int MAX_VARS = 1048576;
    localparam int CNT_W    = $clog2(MAX_VARS + 2);
    localparam int IDX_W    = 20;
    localparam int TOL_W    = 31;
    localparam int DATA_W   = 32;
    localparam int SQ_W     = 63;
    localparam int ACC_W    = 95;
    localparam int PROD_W   = 64;

    localparam logic [DATA_W-1:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [TOL_W-1:0]  TOL_RESET = 31'd1;

    localparam logic [1:0] STATUS_AT_LOWER = 2'd1;
    localparam logic [1:0] STATUS_AT_UPPER = 2'd2;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SQ     = 8'b0000_0010,
        ST_R0     = 8'b0000_0100,
        ST_R1     = 8'b0000_1000,
        ST_L0     = 8'b0001_0000,
        ST_L1     = 8'b0010_0000,
        ST_SUM    = 8'b0100_0000,
        ST_DECIDE = 8'b1000_0000
    } seq_state_t;

    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } mul_req_t;

endpackage

// ===== src/sese_mul.sv =====
// shared 32x32 unsigned multiplier with registered product
module sese_mul (
    input  logic                     clk,
    input  sese_pkg::mul_req_t       req,
    output logic [sese_pkg::PROD_W-1:0] prod
);
    import sese_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(req.a) * PROD_W'(req.b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== src/steepest_edge_entering_select.sv =====
// steepest-edge entering-column selector: sequencer around one shared multiplier
//
//   channel | signals                                             | dir
//   in      | in_valid/in_ready, column_cost, edge_weight,        | in
//           | column_status, last_column                          |
//   out     | out_valid/out_ready, entering_index, found, overflow | out
//   cfg     | cfg_wr_en, cfg_wr_data (optimality tolerance)       | in
//
// an attractive column passes through accept, one square and four 32x32 partial products
// through the single multiplier, one sum and one decide before the next beat can be taken;
// any other column goes from accept straight to decide
// reset clears the scan state and sets the tolerance to one lsb
// the result sits in an output register; a new column is taken while it waits,
// only a last column stalls in decide until the previous result has left
module steepest_edge_entering_select (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [sese_pkg::DATA_W-1:0] column_cost,
    input  logic [sese_pkg::DATA_W-1:0]      edge_weight,
    input  logic [1:0]                       column_status,
    input  logic                             last_column,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [sese_pkg::IDX_W-1:0]       entering_index,
    output logic                             found,
    output logic                             overflow,
    input  logic                             cfg_wr_en,
    input  logic [sese_pkg::TOL_W-1:0]       cfg_wr_data
);
    import sese_pkg::*;

    seq_state_t state_reg, state_next;

    logic [TOL_W-1:0]  tol_reg;
    logic [DATA_W-1:0] mag_reg, mag_next;
    logic [DATA_W-1:0] w_reg, w_next;
    logic              cand_reg, cand_next;
    logic              last_reg, last_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic [ACC_W-1:0]  acc_l_reg, acc_l_next;
    logic [ACC_W-1:0]  acc_r_reg, acc_r_next;

    logic [SQ_W-1:0]   bsq_reg, bsq_next;
    logic [DATA_W-1:0] bw_reg, bw_next;
    logic [IDX_W-1:0]  bpos_reg, bpos_next;
    logic              have_reg, have_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic              out_found_reg, out_found_next;
    logic              out_ovf_reg, out_ovf_next;

    mul_req_t          mreq;
    logic [PROD_W-1:0] prod;

    logic              accept;
    logic              attractive;
    logic signed [DATA_W:0] rc_ext;
    logic signed [DATA_W:0] tol_ext;
    logic [CNT_W-1:0]  cnt_inc;
    logic              better;
    logic              take;
    logic              stall_out;

    sese_mul u_mul (
        .clk  (clk),
        .req  (mreq),
        .prod (prod)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    assign rc_ext  = {column_cost[DATA_W-1], column_cost};
    assign tol_ext = $signed({2'b00, tol_reg});

    always_comb
    begin
        attractive = 1'b0;
        if (column_status == STATUS_AT_LOWER && rc_ext < -tol_ext)
        begin
            attractive = 1'b1;
        end
        else if (column_status == STATUS_AT_UPPER && rc_ext > tol_ext)
        begin
            attractive = 1'b1;
        end
    end

    // operand select for the shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_SQ:
            begin
                mreq.a = mag_reg;
                mreq.b = mag_reg;
            end
            ST_R0:
            begin
                mreq.a = bsq_reg[DATA_W-1:0];
                mreq.b = w_reg;
            end
            ST_R1:
            begin
                mreq.a = {1'b0, bsq_reg[SQ_W-1:DATA_W]};
                mreq.b = w_reg;
            end
            ST_L0:
            begin
                mreq.a = sq_reg[DATA_W-1:0];
                mreq.b = bw_reg;
            end
            ST_L1:
            begin
                mreq.a = {1'b0, sq_reg[SQ_W-1:DATA_W]};
                mreq.b = bw_reg;
            end
            default:
            begin
                mreq.a = mag_reg;
                mreq.b = w_reg;
            end
        endcase
    end

    assign cnt_inc   = (cnt_reg <= CNT_W'(MAX_VARS)) ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign better    = !have_reg || (acc_l_reg > acc_r_reg);
    assign take      = cand_reg && better;
    assign stall_out = last_reg && out_valid_reg && !out_ready;

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        w_next         = w_reg;
        cand_next      = cand_reg;
        last_next      = last_reg;
        sq_next        = sq_reg;
        acc_l_next     = acc_l_reg;
        acc_r_next     = acc_r_reg;
        bsq_next       = bsq_reg;
        bw_next        = bw_reg;
        bpos_next      = bpos_reg;
        have_next      = have_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_idx_next   = out_idx_reg;
        out_found_next = out_found_reg;
        out_ovf_next   = out_ovf_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mag_next  = column_cost[DATA_W-1] ? (~column_cost + DATA_W'(1))
                                                      : column_cost;
                    w_next    = (edge_weight == '0) ? ONE_Q16 : edge_weight;
                    // positions at or past the limit are counted but never picked
                    cand_next = attractive && (cnt_reg < CNT_W'(MAX_VARS));
                    last_next = last_column;
                    state_next = (attractive && (cnt_reg < CNT_W'(MAX_VARS)))
                                 ? ST_SQ : ST_DECIDE;
                end
            end
            ST_SQ:
            begin
                state_next = ST_R0;
            end
            ST_R0:
            begin
                sq_next    = prod[SQ_W-1:0];
                state_next = ST_R1;
            end
            ST_R1:
            begin
                acc_r_next = ACC_W'(prod);
                state_next = ST_L0;
            end
            ST_L0:
            begin
                acc_r_next = acc_r_reg + {prod[SQ_W-1:0], {DATA_W{1'b0}}};
                state_next = ST_L1;
            end
            ST_L1:
            begin
                acc_l_next = ACC_W'(prod);
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                acc_l_next = acc_l_reg + {prod[SQ_W-1:0], {DATA_W{1'b0}}};
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!stall_out)
                begin
                    state_next = ST_IDLE;
                    if (take)
                    begin
                        bsq_next  = sq_reg;
                        bw_next   = w_reg;
                        bpos_next = IDX_W'(cnt_reg);
                        have_next = 1'b1;
                    end
                    if (last_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_found_next = take || have_reg;
                        out_idx_next   = take ? IDX_W'(cnt_reg)
                                              : (have_reg ? bpos_reg : '0);
                        out_ovf_next   = (cnt_inc > CNT_W'(MAX_VARS));
                        // start a fresh scan
                        bsq_next  = '0;
                        bw_next   = ONE_Q16;
                        bpos_next = '0;
                        have_next = 1'b0;
                        cnt_next  = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tol_reg       <= TOL_RESET;
            bsq_reg       <= '0;
            bw_reg        <= ONE_Q16;
            bpos_reg      <= '0;
            have_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wr_en)
            begin
                tol_reg <= cfg_wr_data;
            end
            bsq_reg       <= bsq_next;
            bw_reg        <= bw_next;
            bpos_reg      <= bpos_next;
            have_reg      <= have_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        w_reg         <= w_next;
        cand_reg      <= cand_next;
        last_reg      <= last_next;
        sq_reg        <= sq_next;
        acc_l_reg     <= acc_l_next;
        acc_r_reg     <= acc_r_next;
        out_idx_reg   <= out_idx_next;
        out_found_reg <= out_found_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign out_valid      = out_valid_reg;
    assign entering_index = out_idx_reg;
    assign found          = out_found_reg;
    assign overflow       = out_ovf_reg;

endmodule

// ===== tb/sv/sese_tb_pkg.sv =====
`timescale 1ns / 1ps
// scoreboard with the entering-column predictor for the steepest-edge selector bench
package sese_tb_pkg;

    import sese_pkg::*;

    localparam logic [1:0]       STATUS_BASIC = 2'd0;
    localparam logic [1:0]       STATUS_OTHER = 2'd3;
    localparam logic [TOL_W-1:0] TOL_MAX      = 31'h7FFF_FFFF;
    localparam int               REPORT_LIMIT = 10;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             found;
        logic             overflow;
    } scan_result_t;

    class entering_scoreboard;
        logic [TOL_W-1:0] tolerance;
        logic [63:0]      best_sq;
        logic [31:0]      best_w;
        logic [31:0]      best_pos;
        logic             have_best;
        logic [31:0]      col_count;
        scan_result_t     picks[$];
        int               mismatches;

        function new();
            tolerance  = TOL_RESET;
            mismatches = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            best_sq   = '0;
            best_w    = ONE_Q16;
            best_pos  = '0;
            have_best = 1'b0;
            col_count = '0;
        endfunction

        function void set_tolerance(logic [TOL_W-1:0] value);
            tolerance = value;
        endfunction

        function int pending();
            return picks.size();
        endfunction

        // one accepted column beat
        function void note_column(logic [31:0] cost, logic [31:0] weight,
                                  logic [1:0] status, logic lst);
            longint       rc;
            longint       tol;
            logic [31:0]  w_eff;
            logic [63:0]  sq;
            logic [95:0]  lhs;
            logic [95:0]  rhs;
            logic         attractive;
            logic         better;
            scan_result_t res;
            rc    = $signed(cost);
            tol   = tolerance;
            w_eff = (weight == '0) ? ONE_Q16 : weight;
            attractive = (status == STATUS_AT_LOWER && rc < -tol) ||
                         (status == STATUS_AT_UPPER && rc > tol);
            if (attractive && col_count < MAX_VARS) begin
                sq  = rc * rc;
                // exact ratio compare: sq/w_eff > best_sq/best_w
                lhs = {32'b0, sq} * {64'b0, best_w};
                rhs = {32'b0, best_sq} * {64'b0, w_eff};
                better = !have_best || (lhs > rhs);
                if (better) begin
                    best_sq   = sq;
                    best_w    = w_eff;
                    best_pos  = col_count;
                    have_best = 1'b1;
                end
            end
            if (col_count <= MAX_VARS)
                col_count++;
            if (lst) begin
                res.index    = have_best ? best_pos[IDX_W-1:0] : '0;
                res.found    = have_best;
                res.overflow = (col_count > MAX_VARS);
                picks.push_back(res);
                clear_scan();
            end
        endfunction

        function void check_result(scan_result_t got);
            scan_result_t want;
            logic         bad;
            if (picks.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: index %0d found %0b overflow %0b",
                             got.index, got.found, got.overflow);
                return;
            end
            want = picks.pop_front();
            bad  = (want.index != got.index) || (want.found != got.found) ||
                   (want.overflow != got.overflow);
            if (bad) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                             want.index, want.found, want.overflow,
                             got.index, got.found, got.overflow);
            end
        endfunction
    endclass

endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// top-level bench: drives column scans and checks the selected entering column
module tb;

    import sese_pkg::*;
    import sese_tb_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 850;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              in_valid      = 1'b0;
    logic              in_ready;
    logic [DATA_W-1:0] column_cost   = '0;
    logic [DATA_W-1:0] edge_weight   = '0;
    logic [1:0]        column_status = STATUS_BASIC;
    logic              last_column   = 1'b0;
    logic              out_valid;
    logic              out_ready     = 1'b0;
    logic [IDX_W-1:0]  entering_index;
    logic              found;
    logic              overflow;
    logic              cfg_wr_en     = 1'b0;
    logic [TOL_W-1:0]  cfg_wr_data   = '0;

    logic              steady        = 1'b0;
    logic              hold_off_req  = 1'b0;
    logic [TOL_W-1:0]  cur_tol       = TOL_RESET;

    entering_scoreboard sb = new();

    steepest_edge_entering_select dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .column_cost    (column_cost),
        .edge_weight    (edge_weight),
        .column_status  (column_status),
        .last_column    (last_column),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .entering_index (entering_index),
        .found          (found),
        .overflow       (overflow),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_column(column_cost, edge_weight, column_status, last_column);
            if (out_valid && out_ready)
                sb.check_result('{index: entering_index, found: found, overflow: overflow});
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver: random ready pattern, steady stretches, one long hold-off
    initial
    begin
        int   gap;
        logic hold_done;
        hold_done = 1'b0;
        forever
        begin
            if (hold_off_req && !hold_done)
            begin
                out_ready = 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(negedge clk);
                hold_done = 1'b1;
            end
            else if (steady)
            begin
                out_ready = 1'b1;
                @(negedge clk);
            end
            else
            begin
                out_ready = 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                gap = pick_gap();
                if (gap > 0)
                begin
                    out_ready = 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
        end
    end

    task automatic send_column(input logic [31:0] cost, input logic [31:0] weight,
                               input logic [1:0] status, input logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid      = 1'b0;
            column_cost   = $urandom;
            edge_weight   = $urandom;
            column_status = 2'($urandom_range(0, 3));
            last_column   = 1'($urandom_range(0, 1));
            repeat (gap) @(negedge clk);
        end
        in_valid      = 1'b1;
        column_cost   = cost;
        edge_weight   = weight;
        column_status = status;
        last_column   = lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        sb.set_tolerance(value);
        cur_tol = value;
    endtask

    function automatic logic [TOL_W-1:0] phase_tolerance(int phase);
        logic [31:0] r;
        case (phase % 6)
            0: r = '0;
            1: r = {1'b0, TOL_MAX};
            2: r = ONE_Q16;
            3: r = $urandom_range(0, 255);
            4: r = $urandom;
            default: r = $urandom_range(0, 1 << 20);
        endcase
        return r[TOL_W-1:0];
    endfunction

    // costs cluster around the tolerance edges and the signed extremes
    function automatic logic [31:0] pick_cost(logic [TOL_W-1:0] tol);
        logic [31:0] t;
        logic [31:0] mag;
        t   = {1'b0, tol};
        mag = $urandom_range(0, 1 << 22);
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return t;
                    1: return -t;
                    2: return t + 1;
                    default: return -(t + 1);
                endcase
            end
            3:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom_range(0, 1) ? mag : -mag;
        endcase
    endfunction

    function automatic logic [31:0] pick_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        if (r < 20)
            return '1;
        if (r < 50)
            return $urandom_range(1, 32'h0003_0000);
        return $urandom;
    endfunction

    function automatic logic [1:0] pick_status();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return STATUS_AT_LOWER;
        if (r < 80)
            return STATUS_AT_UPPER;
        if (r < 90)
            return STATUS_BASIC;
        return STATUS_OTHER;
    endfunction

    function automatic int pick_scan_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 10);
        if (r < 95)
            return $urandom_range(11, 30);
        return $urandom_range(40, 80);
    endfunction

    task automatic random_scan(input int len);
        logic [31:0] cost;
        logic [31:0] weight;
        logic [31:0] mag;
        logic [1:0]  status;
        logic [31:0] tie_mag;
        logic [31:0] tie_w;
        logic        have_tie;
        have_tie = 1'b0;
        tie_mag  = '0;
        tie_w    = ONE_Q16;
        for (int i = 0; i < len; i++)
        begin
            status = pick_status();
            weight = pick_weight();
            cost   = pick_cost(cur_tol);
            // now and then repeat an earlier ratio, plain or scaled, to hit ties
            if (have_tie && $urandom_range(0, 9) == 0)
            begin
                mag    = tie_mag;
                weight = tie_w;
                if (tie_mag < 32'h4000_0000 && tie_w < 32'h4000_0000 &&
                    $urandom_range(0, 1))
                begin
                    mag    = tie_mag << 1;
                    weight = tie_w << 2;
                end
                if (mag == 32'h8000_0000 || $urandom_range(0, 1))
                    status = STATUS_AT_LOWER;
                else
                    status = STATUS_AT_UPPER;
                cost = (status == STATUS_AT_LOWER) ? -mag : mag;
            end
            if (status == STATUS_AT_LOWER || status == STATUS_AT_UPPER)
            begin
                tie_mag  = cost[31] ? -cost : cost;
                tie_w    = (weight == '0) ? ONE_Q16 : weight;
                have_tie = 1'b1;
            end
            send_column(cost, weight, status, i == len - 1);
        end
    endtask

    initial
    begin
        int random_sent;
        int phase_sent;
        int budget;
        int len;
        int phase;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // tolerance still at its reset value of one lsb
        send_column(32'hFFFF_FFFE, 32'hFFFF_FFFF, STATUS_AT_LOWER, 1'b0);
        send_column(32'h7FFF_FFFF, 32'hFFFF_FFFF, STATUS_AT_UPPER, 1'b0);
        send_column(32'h8000_0000, 32'h0000_0001, STATUS_BASIC, 1'b0);
        send_column(32'h8000_0000, 32'h0000_0001, STATUS_OTHER, 1'b0);
        send_column(32'h8000_0000, 32'h0000_0000, STATUS_AT_LOWER, 1'b1);
        // costs exactly at the tolerance, then equal ratios: first one wins
        send_column(32'hFFFF_FFFF, 32'h0000_0000, STATUS_AT_LOWER, 1'b0);
        send_column(32'h0000_0001, 32'h0000_0000, STATUS_AT_UPPER, 1'b0);
        send_column(32'hFFFE_0000, 32'h0001_0000, STATUS_AT_LOWER, 1'b0);
        send_column(32'h0002_0000, 32'h0000_0000, STATUS_AT_UPPER, 1'b0);
        send_column(32'h0004_0000, 32'h0004_0000, STATUS_AT_UPPER, 1'b1);
        // wrong side of the bound: nothing found; then a cost just past the bound is found
        send_column(32'h7FFF_FFFF, 32'h0000_0001, STATUS_AT_LOWER, 1'b1);
        send_column(32'h0000_0002, 32'h0000_0001, STATUS_AT_UPPER, 1'b1);
        wait_idle();

        write_tolerance('0);
        send_column(32'h0000_0000, 32'h0000_0005, STATUS_AT_LOWER, 1'b0);
        send_column(32'h0000_0000, 32'h0000_0005, STATUS_AT_UPPER, 1'b0);
        send_column(32'hFFFF_FFFF, 32'h0000_0000, STATUS_AT_LOWER, 1'b1);
        wait_idle();

        // only the most negative cost clears the widest tolerance
        write_tolerance(TOL_MAX);
        send_column(32'h7FFF_FFFF, 32'h0000_0000, STATUS_AT_UPPER, 1'b0);
        send_column(32'h8000_0001, 32'h0000_0000, STATUS_AT_LOWER, 1'b0);
        send_column(32'h8000_0000, 32'hFFFF_FFFF, STATUS_AT_LOWER, 1'b1);
        wait_idle();

        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            write_tolerance(phase_tolerance(phase));
            steady = (phase % 3 == 2);
            if (phase == 2)
                hold_off_req = 1'b1;
            budget     = (phase % 6 == 1) ? 40 : 110;
            phase_sent = 0;
            while (phase_sent < budget)
            begin
                len = pick_scan_length();
                random_scan(len);
                phase_sent += len;
            end
            random_sent += phase_sent;
            phase++;
            steady = 1'b0;
            wait_idle();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/sese_pkg.sv
src/sese_mul.sv
src/steepest_edge_entering_select.sv
tb/sv/sese_tb_pkg.sv
tb/sv/tb.sv
